// ----- sv/efla_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efla_pkg
// Shared types, constants and helpers for the free-list allocator core.
// ----------------------------------------------------------------------------
package efla_pkg;

  // Request kinds carried on the tuser bits of the request beat
  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_FREE    = 2'd1,
    REQ_REALLOC = 2'd2,
    REQ_INIT    = 2'd3
  } req_e;

  localparam logic [16:0] MIN_BLOCK   = 17'd24;
  localparam logic [16:0] MIN_PAYLOAD = 17'd16;
  localparam logic [15:0] SIZE_MASK   = 16'hFFFE;
  localparam logic [16:0] HDR_BYTES   = 17'd8;

  // Round a request up to a multiple of 8, at least the minimum payload
  function automatic logic [16:0] round_req(input logic [15:0] sz);
    logic [16:0] n;
    n = ({1'b0, sz} + 17'd7) & 17'h1FFF8;
    return (n < MIN_PAYLOAD) ? MIN_PAYLOAD : n;
  endfunction

endpackage

// ----- sv/efla_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efla_mem
// Single-port heap metadata store with registered read data.
// ----------------------------------------------------------------------------
module efla_mem #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [15:0]              wdata_i,
  output logic [15:0]              rdata_o
);

  logic [15:0] mem_q [DEPTH];
  logic [15:0] rdata_q;

  // Write or read one word per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/explicit_free_list_allocator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// explicit_free_list_allocator_core
// Heap metadata engine: init, alloc, free and realloc over a free list.
// ----------------------------------------------------------------------------
// One request is in flight at a time; s_axis_tready_o is high only while the
// sequencer is idle. Every step goes through the single-port metadata memory,
// one access per cycle: setup, the first-fit walk over free blocks, the block
// walk for the address check and again for the closing used-byte count, and
// the list unlinks and inserts. After reset the block writes the initial free
// header before it takes the first beat.
module explicit_free_list_allocator_core #(
  parameter int unsigned HEAP_WORDS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request: req_type [1:0]
  input  logic [1:0]  s_axis_tuser_i,
  // request: size [15:0], address [30:16]
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,
  // response: ok [0], result_address [15:1], used_bytes [31:16]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,
  // max_request register
  input  logic        cfg_wr_en_i,
  input  logic [15:0] cfg_wr_data_i
);

  localparam int unsigned AW  = $clog2(HEAP_WORDS);
  localparam logic [16:0] CAP = 17'(HEAP_WORDS * 8);

  typedef enum logic [5:0] {
    S_IW0, S_IW1, S_IW2, S_IDLE, S_DEC, S_ALLOC,
    S_FF0, S_FF1, S_FF2, S_A_FOUND, S_A_CARVE, S_A_DONE,
    S_DT0, S_DT1, S_DT2, S_DT3, S_DT4, S_DT5,
    S_PU0, S_PU1, S_PU2, S_CV0, S_CV1, S_CV2,
    S_CO0, S_CO1, S_CO2, S_CO3, S_CO4,
    S_REL0, S_REL1, S_REL2, S_CHK0, S_CHK1, S_CHK2,
    S_FREE_GO, S_RA_GO, S_RA1, S_RA2, S_RA3,
    S_RC0, S_RC1, S_RC2, S_DONE
  } state_e;

  state_e state_q, state_d, ret_q, ret_d, ret2_q, ret2_d;

  logic [1:0]  type_q, type_d;
  logic [15:0] size_q, size_d;
  logic [14:0] addr_q, addr_d;
  logic [16:0] need_q, need_d;
  logic [15:0] h_q, h_d, x_q, x_d, p_q, p_d, n_q, n_d, cur_q, cur_d;
  logic [15:0] blk_q, blk_d, s2_q, s2_d, hold_q, hold_d;
  logic        halloc_q, halloc_d, found_q, found_d, ok_q, ok_d;
  logic [16:0] b_q, b_d, acc_q, acc_d;
  logic [14:0] res_q, res_d;
  logic [15:0] used_q, used_d, hbytes_q, hbytes_d, front_q, front_d;
  logic [15:0] maxreq_q, maxreq_d;
  logic        out_valid_q, out_valid_d, out_ok_q, out_ok_d;
  logic [14:0] out_addr_q, out_addr_d;
  logic [15:0] out_used_q, out_used_d;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [15:0]   mem_wdata, mem_rdata, sz_rd;
  logic          req_ok;
  logic [16:0]   nn, rem, tgt, hb_in;

  // Word index of a byte offset plus a word offset
  function automatic logic [AW-1:0] widx(input logic [15:0] b, input logic [1:0] off);
    return b[AW+2:3] + AW'(off);
  endfunction

  efla_mem #(.DEPTH(HEAP_WORDS)) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  assign sz_rd  = mem_rdata & efla_pkg::SIZE_MASK;
  assign req_ok = (size_q != 16'd0)
                && ({1'b0, need_q} + {2'b00, used_q} <= {2'b00, hbytes_q})
                && (need_q <= {1'b0, maxreq_q});
  assign nn     = {1'b0, h_q} + efla_pkg::HDR_BYTES + {1'b0, blk_q};
  assign rem    = {1'b0, sz_rd} - need_q;
  assign tgt    = {2'b00, addr_q} - efla_pkg::HDR_BYTES;
  assign hb_in  = {1'b0, size_q & 16'hFFF8};

  // Sequencer next state
  always_comb begin
    state_d = state_q;  ret_d = ret_q;  ret2_d = ret2_q;
    type_d = type_q;  size_d = size_q;  addr_d = addr_q;  need_d = need_q;
    h_d = h_q;  x_d = x_q;  p_d = p_q;  n_d = n_q;  cur_d = cur_q;
    blk_d = blk_q;  s2_d = s2_q;  hold_d = hold_q;  halloc_d = halloc_q;
    found_d = found_q;  ok_d = ok_q;  b_d = b_q;  acc_d = acc_q;  res_d = res_q;
    used_d = used_q;  hbytes_d = hbytes_q;  front_d = front_q;
    maxreq_d = cfg_wr_en_i ? cfg_wr_data_i : maxreq_q;
    out_valid_d = out_valid_q & ~m_axis_tready_i;
    out_ok_d = out_ok_q;  out_addr_d = out_addr_q;  out_used_d = out_used_q;
    mem_we = 1'b0;  mem_addr = '0;  mem_wdata = 16'd0;

    case (state_q)
      // Lay down the single free block
      S_IW0: begin
        mem_we = 1'b1;  mem_addr = widx(16'd0, 2'd0);
        mem_wdata = (hbytes_q - 16'd8) & efla_pkg::SIZE_MASK;
        state_d = S_IW1;
      end
      S_IW1: begin
        mem_we = 1'b1;  mem_addr = widx(16'd0, 2'd1);  state_d = S_IW2;
      end
      S_IW2: begin
        mem_we = 1'b1;  mem_addr = widx(16'd0, 2'd2);  state_d = ret_q;
      end
      // Take a beat
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          type_d = s_axis_tuser_i;
          size_d = s_axis_tdata_i[15:0];
          addr_d = s_axis_tdata_i[30:16];
          need_d = efla_pkg::round_req(s_axis_tdata_i[15:0]);
          state_d = S_DEC;
        end
      end
      // Dispatch on request kind
      S_DEC: begin
        ok_d = 1'b0;  res_d = 15'd0;  state_d = S_RC0;
        case (efla_pkg::req_e'(type_q))
          efla_pkg::REQ_ALLOC: state_d = S_ALLOC;
          efla_pkg::REQ_FREE: begin
            if (addr_q == 15'd0) ok_d = 1'b1;
            else begin ret_d = S_FREE_GO;  state_d = S_CHK0; end
          end
          efla_pkg::REQ_REALLOC: begin
            if (addr_q == 15'd0) state_d = S_ALLOC;
            else if (req_ok) begin ret_d = S_RA_GO;  state_d = S_CHK0; end
          end
          efla_pkg::REQ_INIT: begin
            if (hb_in >= efla_pkg::MIN_BLOCK && hb_in <= CAP) begin
              hbytes_d = hb_in[15:0];  front_d = 16'd1;  ok_d = 1'b1;
              ret_d = S_RC0;  state_d = S_IW0;
            end
          end
          default: state_d = S_RC0;
        endcase
      end
      S_ALLOC: begin
        if (req_ok) begin cur_d = front_q;  ret_d = S_A_FOUND;  state_d = S_FF0; end
        else state_d = S_RC0;
      end
      // First-fit walk
      S_FF0: begin
        if (!cur_q[0]) begin found_d = 1'b0;  state_d = ret_q; end
        else begin
          h_d = cur_q & efla_pkg::SIZE_MASK;  mem_addr = widx(cur_q, 2'd0);
          state_d = S_FF1;
        end
      end
      S_FF1: begin
        if (need_q <= {1'b0, sz_rd}) begin found_d = 1'b1;  state_d = ret_q; end
        else begin mem_addr = widx(h_q, 2'd2);  state_d = S_FF2; end
      end
      S_FF2: begin cur_d = mem_rdata;  state_d = S_FF0; end
      S_A_FOUND: begin
        if (found_q) begin x_d = h_q;  ret2_d = S_A_CARVE;  state_d = S_DT0; end
        else state_d = S_RC0;
      end
      S_A_CARVE: begin ret_d = S_A_DONE;  state_d = S_CV0; end
      S_A_DONE: begin
        res_d = 15'(h_q + 16'd8);  ok_d = 1'b1;
        if (efla_pkg::req_e'(type_q) == efla_pkg::REQ_REALLOC && addr_q != 15'd0) begin
          h_d = hold_q;  state_d = S_REL0;
        end else state_d = S_RC0;
      end
      // Unlink x from the free list
      S_DT0: begin mem_addr = widx(x_q, 2'd1);  state_d = S_DT1; end
      S_DT1: begin p_d = mem_rdata;  mem_addr = widx(x_q, 2'd2);  state_d = S_DT2; end
      S_DT2: begin
        n_d = mem_rdata;
        if (p_q[0]) begin
          mem_we = 1'b1;  mem_addr = widx(p_q, 2'd2);  mem_wdata = mem_rdata;
        end else front_d = mem_rdata;
        state_d = S_DT3;
      end
      S_DT3: begin
        if (n_q[0]) begin
          mem_we = 1'b1;  mem_addr = widx(n_q, 2'd1);  mem_wdata = p_q;
        end
        state_d = S_DT4;
      end
      S_DT4: begin mem_we = 1'b1;  mem_addr = widx(x_q, 2'd1);  state_d = S_DT5; end
      S_DT5: begin mem_we = 1'b1;  mem_addr = widx(x_q, 2'd2);  state_d = ret2_q; end
      // Push x at the list front
      S_PU0: begin
        if (front_q[0]) begin
          mem_we = 1'b1;  mem_addr = widx(front_q, 2'd1);  mem_wdata = x_q | 16'd1;
        end
        state_d = S_PU1;
      end
      S_PU1: begin
        mem_we = 1'b1;  mem_addr = widx(x_q, 2'd2);
        mem_wdata = front_q[0] ? front_q : 16'd0;
        state_d = S_PU2;
      end
      S_PU2: begin
        mem_we = 1'b1;  mem_addr = widx(x_q, 2'd1);
        front_d = x_q | 16'd1;  state_d = ret2_q;
      end
      // Carve need bytes from block h, split off the tail if large enough
      S_CV0: begin mem_addr = widx(h_q, 2'd0);  state_d = S_CV1; end
      S_CV1: begin
        if (rem >= efla_pkg::MIN_BLOCK) begin
          x_d = 16'(h_q + 16'd8 + need_q[15:0]);
          mem_we = 1'b1;  mem_addr = widx(x_d, 2'd0);
          mem_wdata = 16'(rem - efla_pkg::HDR_BYTES) & efla_pkg::SIZE_MASK;
          blk_d = need_q[15:0];  ret2_d = S_CV2;  state_d = S_PU0;
        end else begin
          blk_d = sz_rd;  state_d = S_CV2;
        end
      end
      S_CV2: begin
        mem_we = 1'b1;  mem_addr = widx(h_q, 2'd0);  mem_wdata = blk_q | 16'd1;
        state_d = ret_q;
      end
      // Absorb free right neighbours into h
      S_CO0: begin mem_addr = widx(h_q, 2'd0);  state_d = S_CO1; end
      S_CO1: begin blk_d = sz_rd;  halloc_d = mem_rdata[0];  state_d = S_CO2; end
      S_CO2: begin
        if (nn >= {1'b0, hbytes_q}) state_d = ret_q;
        else begin
          x_d = nn[15:0];  mem_addr = widx(nn[15:0], 2'd0);  state_d = S_CO3;
        end
      end
      S_CO3: begin
        if (mem_rdata[0]) state_d = ret_q;
        else begin s2_d = sz_rd;  ret2_d = S_CO4;  state_d = S_DT0; end
      end
      S_CO4: begin
        blk_d = blk_q + 16'd8 + s2_q;
        mem_we = 1'b1;  mem_addr = widx(h_q, 2'd0);
        mem_wdata = (blk_d & efla_pkg::SIZE_MASK) | {15'd0, halloc_q};
        state_d = S_CO2;
      end
      // Return h to the list and merge rightwards
      S_REL0: begin x_d = h_q;  ret2_d = S_REL1;  state_d = S_PU0; end
      S_REL1: begin mem_addr = widx(h_q, 2'd0);  state_d = S_REL2; end
      S_REL2: begin
        mem_we = 1'b1;  mem_addr = widx(h_q, 2'd0);  mem_wdata = sz_rd;
        ret_d = S_RC0;  state_d = S_CO0;
      end
      // Check the address is the payload of an allocated block
      S_CHK0: begin
        if (addr_q < 15'd8 || addr_q[2:0] != 3'd0) begin
          found_d = 1'b0;  state_d = ret_q;
        end else begin b_d = 17'd0;  state_d = S_CHK1; end
      end
      S_CHK1: begin
        if (b_q >= {1'b0, hbytes_q} || b_q > tgt) begin
          found_d = 1'b0;  state_d = ret_q;
        end else begin mem_addr = widx(b_q[15:0], 2'd0);  state_d = S_CHK2; end
      end
      S_CHK2: begin
        if (b_q == tgt) begin found_d = mem_rdata[0];  state_d = ret_q; end
        else begin
          b_d = b_q + efla_pkg::HDR_BYTES + {1'b0, sz_rd};  state_d = S_CHK1;
        end
      end
      S_FREE_GO: begin
        if (found_q) begin
          h_d = tgt[15:0];  ok_d = 1'b1;  state_d = S_REL0;
        end else state_d = S_RC0;
      end
      // Realloc: grow or shrink in place, else move
      S_RA_GO: begin
        if (found_q) begin
          h_d = tgt[15:0];  hold_d = tgt[15:0];  ret_d = S_RA1;  state_d = S_CO0;
        end else state_d = S_RC0;
      end
      S_RA1: begin mem_addr = widx(h_q, 2'd0);  state_d = S_RA2; end
      S_RA2: begin
        if (need_q <= {1'b0, sz_rd}) begin ret_d = S_RA3;  state_d = S_CV0; end
        else begin cur_d = front_q;  ret_d = S_A_FOUND;  state_d = S_FF0; end
      end
      S_RA3: begin res_d = addr_q;  ok_d = 1'b1;  state_d = S_RC0; end
      // Sum free payloads over the heap
      S_RC0: begin b_d = 17'd0;  acc_d = 17'd0;  state_d = S_RC1; end
      S_RC1: begin
        if (b_q >= {1'b0, hbytes_q}) begin
          used_d = (acc_q <= {1'b0, hbytes_q}) ? 16'({1'b0, hbytes_q} - acc_q) : 16'd0;
          state_d = S_DONE;
        end else begin mem_addr = widx(b_q[15:0], 2'd0);  state_d = S_RC2; end
      end
      S_RC2: begin
        if (!mem_rdata[0]) acc_d = acc_q + {1'b0, sz_rd};
        b_d = b_q + efla_pkg::HDR_BYTES + {1'b0, sz_rd};
        state_d = S_RC1;
      end
      // Hand the response beat over
      S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;  out_ok_d = ok_q;
          out_addr_d = ok_q ? res_q : 15'd0;  out_used_d = used_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IW0;  ret_q <= S_IDLE;  ret2_q <= S_IDLE;
      type_q <= 2'd0;  size_q <= 16'd0;  addr_q <= 15'd0;  need_q <= 17'd0;
      h_q <= 16'd0;  x_q <= 16'd0;  p_q <= 16'd0;  n_q <= 16'd0;  cur_q <= 16'd0;
      blk_q <= 16'd0;  s2_q <= 16'd0;  hold_q <= 16'd0;  halloc_q <= 1'b0;
      found_q <= 1'b0;  ok_q <= 1'b0;  b_q <= 17'd0;  acc_q <= 17'd0;
      res_q <= 15'd0;  used_q <= 16'd8;  hbytes_q <= CAP[15:0];  front_q <= 16'd1;
      maxreq_q <= 16'hFFFF;
      out_valid_q <= 1'b0;  out_ok_q <= 1'b0;  out_addr_q <= 15'd0;
      out_used_q <= 16'd0;
    end else begin
      state_q <= state_d;  ret_q <= ret_d;  ret2_q <= ret2_d;
      type_q <= type_d;  size_q <= size_d;  addr_q <= addr_d;  need_q <= need_d;
      h_q <= h_d;  x_q <= x_d;  p_q <= p_d;  n_q <= n_d;  cur_q <= cur_d;
      blk_q <= blk_d;  s2_q <= s2_d;  hold_q <= hold_d;  halloc_q <= halloc_d;
      found_q <= found_d;  ok_q <= ok_d;  b_q <= b_d;  acc_q <= acc_d;
      res_q <= res_d;  used_q <= used_d;  hbytes_q <= hbytes_d;  front_q <= front_d;
      maxreq_q <= maxreq_d;
      out_valid_q <= out_valid_d;  out_ok_q <= out_ok_d;  out_addr_q <= out_addr_d;
      out_used_q <= out_used_d;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_used_q, out_addr_q, out_ok_q};

  // One request at a time: no new beat right after one is taken
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("request taken while busy");

  // A failed request hands out no address
  a_fail_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_ok_q || out_addr_q == 15'd0))
    else $error("failed response carries an address");

  // Freshly counted used bytes never exceed the heap
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> (used_q <= hbytes_q))
    else $error("used bytes beyond heap");

  // A live list front points at an 8-byte aligned header
  a_front_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_q[0] |-> (front_q[2:1] == 2'd0))
    else $error("list front misaligned");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Request/response test of the free-list allocator core. A behavioral heap
// model tracks headers, links and the free list, predicts ok, address and
// used bytes for every request beat, and each response beat is compared
// against the oldest prediction. Directed heap cases run first, then random
// init/alloc/free/realloc traffic with sender and receiver stalls.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned NWORDS   = 4096;
  localparam int unsigned CAP      = NWORDS * 8;
  localparam int unsigned CYC_MAX  = 40000000;

  // Field order matches the response beat, ok in the lowest bit
  typedef struct packed {
    logic [15:0] used;
    logic [14:0] addr;
    logic        ok;
  } resp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic        cfg_wr_en_i = 1'b0;
  logic [15:0] cfg_wr_data_i = '0;

  explicit_free_list_allocator_core #(.HEAP_WORDS(NWORDS)) u_dut (
    .clk_i, .rst_ni,
    .s_axis_tuser_i,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o,
    .cfg_wr_en_i, .cfg_wr_data_i
  );

  always #5 clk_i = ~clk_i;

  // Heap model state
  logic [15:0] meta [NWORDS];
  logic [15:0] front_q;
  logic [15:0] heap_sz;
  logic [15:0] used_q;
  logic [15:0] max_req;

  resp_t       pending_resp [$];
  int          err_cnt = 0;
  int          cyc = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  int unsigned live_addr [$];

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic int unsigned mrd(int unsigned w);
    return (w < NWORDS) ? meta[w] : 0;
  endfunction
  function automatic void mwr(int unsigned w, int unsigned v);
    if (w < NWORDS) meta[w] = v[15:0];
  endfunction
  function automatic int unsigned bsz(int unsigned h);
    return mrd(h >> 3) & 16'hFFFE;
  endfunction
  function automatic int unsigned bal(int unsigned h);
    return mrd(h >> 3) & 1;
  endfunction
  function automatic void set_hdr(int unsigned h, int unsigned s, int unsigned a);
    mwr(h >> 3, (s & 16'hFFFE) | (a & 1));
  endfunction

  function automatic void list_push(int unsigned h);
    if (front_q[0]) begin
      mwr(((front_q & 16'hFFFE) >> 3) + 1, h | 1);
      mwr((h >> 3) + 2, front_q);
    end else begin
      mwr((h >> 3) + 2, 0);
    end
    mwr((h >> 3) + 1, 0);
    front_q = 16'(h | 1);
  endfunction

  function automatic void list_unlink(int unsigned h);
    int unsigned p, n;
    p = mrd((h >> 3) + 1);
    n = mrd((h >> 3) + 2);
    if (p & 1) mwr(((p & 16'hFFFE) >> 3) + 2, n);
    else front_q = n[15:0];
    if (n & 1) mwr(((n & 16'hFFFE) >> 3) + 1, p);
    mwr((h >> 3) + 1, 0);
    mwr((h >> 3) + 2, 0);
  endfunction

  function automatic void merge_right(int unsigned h);
    int unsigned n;
    for (int i = 0; i < NWORDS; i++) begin
      n = h + 8 + bsz(h);
      if (n >= heap_sz || bal(n)) break;
      list_unlink(n);
      set_hdr(h, bsz(h) + 8 + bsz(n), bal(h));
    end
  endfunction

  function automatic void split_take(int unsigned h, int unsigned need);
    int unsigned take, rem;
    take = bsz(h);
    rem = take - need;
    if (rem >= 24) begin
      set_hdr(h + 8 + need, rem - 8, 0);
      list_push(h + 8 + need);
      take = need;
    end
    set_hdr(h, take, 1);
  endfunction

  function automatic int unsigned round_up(int unsigned s);
    int unsigned n;
    n = (s + 7) & ~32'd7;
    return (n < 16) ? 16 : n;
  endfunction

  function automatic bit req_fits(int unsigned s);
    int unsigned need;
    need = round_up(s);
    return s != 0 && need + used_q <= heap_sz && need <= max_req;
  endfunction

  function automatic bit heap_alloc(int unsigned s, output int unsigned addr);
    int unsigned need, cur, h;
    bit found;
    need = round_up(s);
    addr = 0;
    found = 0;
    if (!req_fits(s)) return 0;
    cur = front_q;
    for (int i = 0; i < NWORDS && cur[0] && !found; i++) begin
      h = cur & 16'hFFFE;
      if (need <= bsz(h)) found = 1;
      else cur = mrd((h >> 3) + 2);
    end
    if (!found) return 0;
    list_unlink(h);
    split_take(h, need);
    addr = h + 8;
    return 1;
  endfunction

  function automatic void heap_release(int unsigned h);
    list_push(h);
    set_hdr(h, bsz(h), 0);
    merge_right(h);
  endfunction

  function automatic bit is_live(int unsigned a);
    int unsigned b, h;
    if (a < 8 || a[2:0] != 0) return 0;
    h = a - 8;
    b = 0;
    for (int i = 0; i < NWORDS && b < heap_sz; i++) begin
      if (b == h) return bal(b) != 0;
      if (b > h) return 0;
      b += 8 + bsz(b);
    end
    return 0;
  endfunction

  function automatic void heap_reset();
    foreach (meta[i]) meta[i] = '0;
    heap_sz = CAP[15:0];
    set_hdr(0, CAP - 8, 0);
    front_q = 16'd1;
    used_q = 16'd8;
    max_req = 16'hFFFF;
  endfunction

  // Apply one request to the heap model and return the expected response
  function automatic resp_t heap_step(efla_pkg::req_e kind, int unsigned s, int unsigned a);
    resp_t r;
    int unsigned res, na, b, freepay, hb;
    bit ok;
    ok = 0;
    res = 0;
    case (kind)
      efla_pkg::REQ_ALLOC: begin
        ok = heap_alloc(s, res);
      end
      efla_pkg::REQ_FREE: begin
        if (a == 0) ok = 1;
        else if (is_live(a)) begin
          heap_release(a - 8);
          ok = 1;
        end
      end
      efla_pkg::REQ_REALLOC: begin
        if (a == 0) ok = heap_alloc(s, res);
        else if (is_live(a) && req_fits(s)) begin
          merge_right(a - 8);
          if (round_up(s) <= bsz(a - 8)) begin
            split_take(a - 8, round_up(s));
            res = a;
            ok = 1;
          end else if (heap_alloc(s, na)) begin
            heap_release(a - 8);
            res = na;
            ok = 1;
          end
        end
      end
      default: begin
        hb = s & ~32'd7;
        if (hb >= 24 && hb <= CAP) begin
          heap_sz = hb[15:0];
          set_hdr(0, hb - 8, 0);
          mwr(1, 0);
          mwr(2, 0);
          front_q = 16'd1;
          ok = 1;
        end
      end
    endcase
    // Recount used bytes over the block chain
    b = 0;
    freepay = 0;
    for (int i = 0; i < NWORDS && b < heap_sz; i++) begin
      if (!bal(b)) freepay += bsz(b);
      b += 8 + bsz(b);
    end
    used_q = 16'((freepay <= heap_sz) ? heap_sz - freepay : 0);
    r.ok = ok;
    r.addr = ok ? res[14:0] : 15'd0;
    r.used = used_q;
    return r;
  endfunction

  // Drop one address from the live list
  function automatic void drop_live(int unsigned a);
    int idx [$];
    idx = live_addr.find_first_index(x) with (x == a);
    if (idx.size() != 0) live_addr.delete(idx[0]);
  endfunction

  // Send one request beat; predict at acceptance
  task automatic send_req(input efla_pkg::req_e kind, input int unsigned s,
                          input int unsigned a);
    resp_t r;
    s = s & 32'hFFFF;
    a = a & 32'h7FFF;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= {1'b0, a[14:0], s[15:0]};
    do @(posedge clk_i); while (!s_axis_tready_o);
    r = heap_step(kind, s, a);
    pending_resp.push_back(r);
    if (r.ok && r.addr != 0) begin
      if (kind == efla_pkg::REQ_REALLOC) drop_live(a);
      live_addr.push_back(r.addr);
    end
    if (r.ok && kind == efla_pkg::REQ_FREE) drop_live(a);
    if (r.ok && kind == efla_pkg::REQ_INIT) live_addr.delete();
  endtask

  // Receiver stall pattern
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle);
  end

  // Compare each response beat with the oldest prediction
  always @(posedge clk_i) begin
    resp_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (pending_resp.size() == 0) report("response beat with nothing pending");
      else begin
        want = pending_resp.pop_front();
        if (got.ok !== want.ok)
          report($sformatf("ok got %0d want %0d", got.ok, want.ok));
        if (got.addr !== want.addr)
          report($sformatf("address got %0d want %0d", got.addr, want.addr));
        if (got.used !== want.used)
          report($sformatf("used got %0d want %0d", got.used, want.used));
      end
    end
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cyc++;
    if (cyc > CYC_MAX) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_max(input int unsigned v);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= v[15:0];
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    max_req = v[15:0];
  endtask

  function automatic int unsigned pick_live();
    if (live_addr.size() == 0) return 0;
    return live_addr[$urandom_range(live_addr.size() - 1)];
  endfunction

  // Extremes, every request kind and each corner of the heap
  task automatic test_directed();
    int unsigned a;
    send_req(efla_pkg::REQ_ALLOC, 0, 0);               // zero size
    send_req(efla_pkg::REQ_FREE, 0, 0);                // null free
    send_req(efla_pkg::REQ_ALLOC, 1, 0);               // minimum payload
    send_req(efla_pkg::REQ_ALLOC, 65535, 0);           // too large
    send_req(efla_pkg::REQ_ALLOC, 24, 0);
    send_req(efla_pkg::REQ_ALLOC, 100, 0);
    a = pick_live();
    send_req(efla_pkg::REQ_FREE, 0, a + 4);            // unaligned free
    send_req(efla_pkg::REQ_FREE, 0, 32767);            // beyond heap
    send_req(efla_pkg::REQ_REALLOC, 40, 0);            // null realloc
    send_req(efla_pkg::REQ_REALLOC, 0, 8);             // zero size realloc
    send_req(efla_pkg::REQ_REALLOC, 200, 8);           // grow
    send_req(efla_pkg::REQ_FREE, 0, 8);
    send_req(efla_pkg::REQ_FREE, 0, 8);                // double free
    send_req(efla_pkg::REQ_REALLOC, 8, 8);             // realloc of free block
    send_req(efla_pkg::REQ_INIT, 23, 0);               // too small heap
    send_req(efla_pkg::REQ_INIT, 65535, 0);            // too large heap
    send_req(efla_pkg::REQ_INIT, 31, 0);               // minimum heap
    send_req(efla_pkg::REQ_ALLOC, 16, 0);
    send_req(efla_pkg::REQ_ALLOC, 16, 0);              // no room
    send_req(efla_pkg::REQ_INIT, 32768, 0);            // full capacity
    send_req(efla_pkg::REQ_ALLOC, 32760, 0);
    send_req(efla_pkg::REQ_FREE, 0, 8);
    drain();
    write_max(0);
    send_req(efla_pkg::REQ_ALLOC, 1, 0);               // over the request limit
    drain();
    write_max(16);
    send_req(efla_pkg::REQ_ALLOC, 16, 0);
    send_req(efla_pkg::REQ_ALLOC, 17, 0);
    drain();
  endtask

  // Random init/alloc/free/realloc traffic over a small heap
  task automatic test_random(input int n);
    int unsigned k, s, a, hb;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      s = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 300);
      a = pick_live();
      hb = ($urandom_range(3) == 0) ? $urandom : 2048 + $urandom_range(6000);
      if (k < 3) send_req(efla_pkg::REQ_INIT, hb, 0);
      else if (k < 40) send_req(efla_pkg::REQ_ALLOC, s, 0);
      else if (k < 70) send_req(efla_pkg::REQ_FREE, 0, a);
      else if (k < 88)
        send_req(efla_pkg::REQ_REALLOC, s, $urandom_range(4) == 0 ? 0 : a);
      else if (k < 94) send_req(efla_pkg::REQ_FREE, 0, $urandom_range(32767));
      else send_req(efla_pkg::REQ_REALLOC, s, $urandom_range(32767));
    end
    drain();
  endtask

  initial begin
    heap_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    write_max(65535);
    send_req(efla_pkg::REQ_INIT, 4096, 0);
    send_idle = 9;
    recv_idle = 83;
    test_random(280);
    write_max(200);
    send_idle = 83;
    recv_idle = 9;
    test_random(280);
    write_max(1 + $urandom_range(65534));
    send_idle = 0;
    recv_idle = 0;
    test_random(290);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- explicit_free_list_allocator_core.f -----
sv/efla_pkg.sv
sv/efla_mem.sv
sv/explicit_free_list_allocator_core.sv
verif/tb.sv
